### hdl/mcbt_pkg.sv
// shared constants, codes and types for the midi clock tempo tracker
`timescale 1ns / 1ps
package mcbt_pkg;

    // default values of the top level parameters
    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int TPQ_DEF       = 24;

    // fixed field widths
    localparam int TEMPO_W    = 23;
    localparam int DELTA_W    = 22;
    localparam int WEIGHT_W   = 17;
    localparam int REQ_W      = 2;
    localparam int TS_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 32;

    localparam logic [63:0] US_PER_MINUTE = 64'd60000000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    // register reset values
    localparam logic [DELTA_W-1:0]  MIN_DELTA_RST = 22'd1000;
    localparam logic [DELTA_W-1:0]  MAX_DELTA_RST = 22'd2000000;
    localparam logic [WEIGHT_W-1:0] SMOOTH_RST    = 17'd3277;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } t_state;

endpackage

### hdl/mcbt_sdiv.sv
// bit-serial restoring divider of a constant dividend by the tick interval
`timescale 1ns / 1ps
module mcbt_sdiv #(
    parameter int          DIV_W    = mcbt_pkg::TIME_BITS_DEF,
    parameter int          DVD_W    = 30,
    parameter logic [63:0] DIVIDEND = 64'd640000000
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DIV_W-1:0]             i_divisor,
    output logic                         o_done,
    output logic [mcbt_pkg::TEMPO_W-1:0] o_quotient
);
    import mcbt_pkg::*;

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVD_W-1:0]   r_dvd;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_den;
    logic [TEMPO_W-1:0] r_quo;
    logic               r_ovf;

    logic [DIV_W:0]     rem_sh;
    logic [DIV_W:0]     rem_sub;
    logic               q_bit;

    // one dividend bit enters the partial remainder per cycle
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DIVIDEND[DVD_W-1:0];
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            // a bit pushed out of the top means the tempo saturates
            r_ovf <= r_ovf | r_quo[TEMPO_W-1];
            r_quo <= {r_quo[TEMPO_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_ovf ? {TEMPO_W{1'b1}} : r_quo;

endmodule

### hdl/midi_clock_bpm_tracker_top.sv
// midi clock tempo tracker: tick interval check, serial divide and serial averaging
// path: start, stop, ignored, first and rejected ticks go from idle to the done state, then to the output register
// path: a tick that updates the tempo goes through the divide, difference, multiply, sum and done states,
//   using the bit-serial divider (one quotient bit a cycle) and the 17-step weight multiply
// flow: one item at a time; a new item is taken only in idle, after the last result is loaded for output
// reset: synchronous active low; tempo and timing cleared, registers at their defaults
`timescale 1ns / 1ps
module midi_clock_bpm_tracker_top #(
    parameter int TIME_BITS         = mcbt_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS         = mcbt_pkg::FRAC_BITS_DEF,
    parameter int TICKS_PER_QUARTER = mcbt_pkg::TPQ_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mcbt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mcbt_pkg::DELTA_W-1:0]    i_cfg_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mcbt_pkg::TS_W-1:0]       s_axis_tdata,   // [31:0] timestamp_us
    input  logic [mcbt_pkg::REQ_W-1:0]      s_axis_tuser,   // [1:0] req_type
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [22:0] bpm_q8, [23] bpm_shown, [24] anomaly, [25] playing, [31:26] zero
    output logic [mcbt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mcbt_pkg::*;

    localparam logic [63:0] DIVIDEND = (US_PER_MINUTE << FRAC_BITS) / TICKS_PER_QUARTER;
    localparam int DVD_W  = $clog2(DIVIDEND + 1);
    localparam int CMP_W  = (TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W;
    localparam int DIFF_W = TEMPO_W + 1;
    localparam int ACC_W  = DIFF_W + WEIGHT_W + 1;
    localparam int MCNT_W = $clog2(WEIGHT_W);
    localparam int PAD_W  = OUT_DATA_W - TEMPO_W - 3;

    // configuration
    logic [DELTA_W-1:0]  r_min_delta;
    logic [DELTA_W-1:0]  r_max_delta;
    logic [WEIGHT_W-1:0] r_smooth;

    // timing state
    logic [TIME_BITS-1:0] r_last;
    logic                 r_have;
    logic [TEMPO_W-1:0]   r_tempo;
    logic                 r_run;
    logic                 r_anom;

    t_state r_state;
    t_state n_state;

    // averaging datapath
    logic signed [DIFF_W-1:0] r_diff;
    logic [WEIGHT_W-1:0]      r_w;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MCNT_W-1:0]        r_mcnt;

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic                 in_fire;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [TEMPO_W-1:0]   div_quo;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] delta;
    logic                 delta_bad;
    logic                 tick_good;
    logic [WEIGHT_W-1:0]  w_sat;
    logic                 mul_last;
    logic [DIFF_W:0]      tempo_sum;

    always_comb begin
        now       = TIME_BITS'(s_axis_tdata);
        delta     = now - r_last;
        delta_bad = (delta == '0)
                 || (CMP_W'(delta) > CMP_W'(r_max_delta))
                 || (CMP_W'(delta) < CMP_W'(r_min_delta));
        tick_good = (s_axis_tuser == REQ_TICK) && r_run && r_have && !delta_bad;
        w_sat     = (r_smooth > WEIGHT_ONE) ? WEIGHT_ONE : r_smooth;
        mul_last  = r_mcnt == MCNT_W'(WEIGHT_W - 1);
        // tempo + floor(diff * w / 65536)
        tempo_sum = {2'b00, r_tempo} + (DIFF_W + 1)'(r_acc >>> 16);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = tick_good ? ST_DIV : ST_DONE;
            ST_DIV:  if (div_done) n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL:  if (mul_last) n_state = ST_SUM;
            ST_SUM:  n_state = ST_DONE;
            ST_DONE: if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DONE: out_load = !r_m_valid || m_axis_tready;
            default: ;
        endcase
        in_fire   = s_axis_tvalid && s_axis_tready;
        div_start = in_fire && tick_good;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delta <= MIN_DELTA_RST;
            r_max_delta <= MAX_DELTA_RST;
            r_smooth    <= SMOOTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_DELTA: r_min_delta <= i_cfg_data;
                CFG_MAX_DELTA: r_max_delta <= i_cfg_data;
                CFG_SMOOTHING: r_smooth    <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // item decode and timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_have  <= 1'b0;
            r_tempo <= '0;
            r_run   <= 1'b0;
            r_anom  <= 1'b0;
        end else if (in_fire) begin
            r_anom <= 1'b0;
            case (s_axis_tuser)
                REQ_TICK: begin
                    if (r_run) begin
                        if (r_have && delta_bad) begin
                            r_last  <= '0;
                            r_have  <= 1'b0;
                            r_tempo <= '0;
                            r_run   <= 1'b0;
                            r_anom  <= 1'b1;
                        end else begin
                            r_last <= now;
                            r_have <= 1'b1;
                        end
                    end
                end
                REQ_START: r_run <= 1'b1;
                REQ_STOP: begin
                    r_last  <= '0;
                    r_have  <= 1'b0;
                    r_tempo <= '0;
                    r_run   <= 1'b0;
                end
                default: ;
            endcase
        end else if (r_state == ST_SUM) begin
            r_tempo <= tempo_sum[TEMPO_W-1:0];
        end
    end

    // serial multiply of (inst - tempo) by the weight, weight msb first
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIFF) begin
            r_diff <= $signed({1'b0, div_quo}) - $signed({1'b0, r_tempo});
            r_w    <= w_sat;
            r_acc  <= '0;
            r_mcnt <= '0;
        end else if (r_state == ST_MUL) begin
            r_acc  <= (r_acc <<< 1) + (r_w[WEIGHT_W-1] ? ACC_W'(r_diff) : '0);
            r_w    <= {r_w[WEIGHT_W-2:0], 1'b0};
            r_mcnt <= r_mcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {{PAD_W{1'b0}}, r_run, r_anom, r_tempo != '0, r_tempo};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    mcbt_sdiv #(
        .DIV_W    (TIME_BITS),
        .DVD_W    (DVD_W),
        .DIVIDEND (DIVIDEND)
    ) u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (delta),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

`ifndef ASSERT_OFF
    a_shown_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TEMPO_W] == (m_axis_tdata[TEMPO_W-1:0] != '0)))
        else $error("bpm_shown disagrees with tempo");
    a_anomaly_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[TEMPO_W+1])
        |-> (!m_axis_tdata[TEMPO_W+2] && m_axis_tdata[TEMPO_W-1:0] == '0))
        else $error("anomaly item still shows tempo or playing");
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tuser == REQ_STOP) |=> (r_tempo == '0 && !r_run && !r_have))
        else $error("stop did not clear timing");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside divide state");
    a_diff_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIFF |-> $past(div_done))
        else $error("average started without a quotient");
`endif

endmodule
